// ===== hw/rtl/ppiir_pkg.sv =====
`default_nettype none

package ppiir_pkg;

   localparam int POINTS_DEF = 4096;
   localparam int ORDER_DEF  = 3;
   localparam int ORDER_MAX  = 3;

   localparam int POINT_W    = 12;
   localparam int DATA_W     = 32;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int WIDE_W     = 48;
   localparam int FIELD_FRAC = 16;
   localparam int COEF_FRAC  = 28;
   localparam int TERM_W     = PROD_W - COEF_FRAC;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 2;
   localparam int CSR_IDX_W  = 3;

   localparam int UPD_BIT = 0;
   localparam int SAT_BIT = 1;

   localparam logic signed [WIDE_W-1:0] SAT_HI =
      {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] SAT_LO =
      {{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_COEF_0,
      CSR_NUM_COEF_1,
      CSR_NUM_COEF_2,
      CSR_NUM_COEF_3,
      CSR_DEN_COEF_1,
      CSR_DEN_COEF_2,
      CSR_DEN_COEF_3
   } csr_index_type;

   typedef struct packed {
      logic               vld;
      logic [POINT_W-1:0] point;
      logic               in_range;
      logic               upd;
   } ctl_type;

   typedef struct packed {
      logic                     clip;
      logic signed [DATA_W-1:0] val;
   } sat_type;

   function automatic sat_type sat32(input logic signed [WIDE_W-1:0] v);
      sat_type r;
      if (v > SAT_HI) begin
         r.clip = 1'b1;
         r.val  = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (v < SAT_LO) begin
         r.clip = 1'b1;
         r.val  = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r.clip = 1'b0;
         r.val  = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/per_point_iir_polarization_update_unit.sv =====
`default_nettype none

// channel  dir  handshake             payload
// req      in   req_tvalid/tready     tdata: point_index, field_value, sigma_value
// rsp      out  rsp_tvalid/tready     tdata: out_point_index, polarization;
//                                     tuser: was_updated, saturated
// csr      in   csr_wr_en             csr_index, csr_wdata
//
// One beat per cycle while req_tready is high; a result passes through the five
// pipeline stages and the output register. A beat whose point still has an update
// in the pipeline waits until that update writes the state memory back, which an
// output stall can delay. After reset a clearing sweep zeroes all POINTS state
// memory words; req_tready stays low during it.
// rsp_tready low stalls the pipeline only once its last stage and the
// output register are both full.

module per_point_iir_polarization_update_unit #(
   parameter int POINTS = ppiir_pkg::POINTS_DEF,
   parameter int ORDER  = ppiir_pkg::ORDER_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // point_index[11:0], field_value[43:12], sigma_value[75:44], zero pad
   input  wire logic [ppiir_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // out_point_index[11:0], polarization[43:12], zero pad
   output logic [ppiir_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // was_updated[0], saturated[1]
   output logic [ppiir_pkg::RSP_USER_W-1:0]         rsp_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_wr_en,
   input  wire logic [ppiir_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ppiir_pkg::DATA_W-1:0]        csr_wdata
);
   import ppiir_pkg::*;

   localparam int ADDR_W = (POINTS > 1) ? $clog2(POINTS) : 1;
   localparam int WORD_W = DATA_W * (ORDER + 1);
   localparam int STAGES = 5;
   localparam logic [31:0] POINTS_U = 32'(POINTS);
   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(POINTS - 1);

   logic signed [DATA_W-1:0] num_coef_ff [0:ORDER_MAX];
   logic signed [DATA_W-1:0] den_coef_ff [1:ORDER_MAX];

   logic              clr_active_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   logic [WORD_W-1:0] mem [0:POINTS-1];
   logic [WORD_W-1:0] rdata_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [WORD_W-1:0] mem_wdata;

   ctl_type ctl_ff [1:STAGES];
   ctl_type ctl_in;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [DATA_W-1:0] u_ff;
   logic                     clip2_ff;
   logic [WORD_W-1:0]        word2_ff;
   logic signed [PROD_W-1:0] bu_ff [0:ORDER];
   logic                     clip3_ff;
   logic [WORD_W-1:0]        word3_ff;
   logic signed [DATA_W-1:0] p_ff;
   logic signed [TERM_W-1:0] bt_ff [1:ORDER];
   logic                     clip4_ff;
   logic [WORD_W-1:0]        word4_ff;
   logic signed [DATA_W-1:0] p5_ff;
   logic signed [TERM_W-1:0] bt5_ff [1:ORDER];
   logic signed [PROD_W-1:0] ap_ff [1:ORDER];
   logic                     clip5_ff;
   logic [WORD_W-1:0]        word5_ff;

   logic                     out_vld_ff;
   logic [POINT_W-1:0]       out_point_ff;
   logic [DATA_W-1:0]        out_pol_ff;
   logic                     out_upd_ff;
   logic                     out_sat_ff;

   logic [POINT_W-1:0]       req_point;
   logic signed [DATA_W-1:0] req_field;
   logic signed [DATA_W-1:0] req_sigma;
   logic                     accept;
   logic                     advance;
   logic                     hazard;
   logic                     dup_upd;

   sat_type                  u_sat_in;
   logic signed [WIDE_W-1:0] p_sum_in;
   sat_type                  p_sat_in;
   logic signed [DATA_W-1:0] d5 [0:ORDER];
   logic signed [DATA_W-1:0] dnew [0:ORDER-1];
   logic                     dclip;
   logic [WORD_W-1:0]        wb_word;
   logic [DATA_W-1:0]        pol_in;
   logic                     sat_in;

   assign req_point = req_tdata[POINT_W-1:0];
   assign req_field = req_tdata[POINT_W +: DATA_W];
   assign req_sigma = req_tdata[POINT_W+DATA_W +: DATA_W];

   assign advance    = !ctl_ff[STAGES].vld || !out_vld_ff || rsp_tready;
   assign req_tready = advance && !clr_active_ff && !hazard;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      hazard = 1'b0;
      for (int k = 1; k <= STAGES; k++) begin
         if (ctl_ff[k].vld && ctl_ff[k].upd && (ctl_ff[k].point == req_point)) begin
            hazard = 1'b1;
         end
      end
   end

   always_comb begin
      ctl_in.vld      = accept;
      ctl_in.point    = req_point;
      ctl_in.in_range = (32'(req_point) < POINTS_U);
      ctl_in.upd      = ctl_in.in_range && (req_sigma != '0);
   end

   assign u_sat_in = sat32($signed(prod_ff[PROD_W-1:FIELD_FRAC]));
   assign p_sum_in = WIDE_W'($signed(word3_ff[DATA_W +: DATA_W]))
                   + WIDE_W'($signed(bu_ff[0][PROD_W-1:COEF_FRAC]));
   assign p_sat_in = sat32(p_sum_in);

   always_comb begin
      logic signed [WIDE_W-1:0] dsum;
      sat_type                  ds;
      dclip = 1'b0;
      dsum  = '0;
      for (int j = 0; j < ORDER; j++) begin
         d5[j] = word5_ff[DATA_W*(j+1) +: DATA_W];
      end
      d5[ORDER] = '0;
      for (int j = 0; j < ORDER; j++) begin
         dsum = WIDE_W'(d5[j+1]) + WIDE_W'(bt5_ff[j+1])
              - WIDE_W'($signed(ap_ff[j+1][PROD_W-1:COEF_FRAC]));
         ds      = sat32(dsum);
         dnew[j] = ds.val;
         dclip   = dclip | ds.clip;
      end
   end

   always_comb begin
      wb_word = '0;
      wb_word[DATA_W-1:0] = p5_ff;
      for (int j = 0; j < ORDER; j++) begin
         wb_word[DATA_W*(j+1) +: DATA_W] = dnew[j];
      end
   end

   always_comb begin
      if (!ctl_ff[STAGES].in_range) begin
         pol_in = '0;
      end else if (ctl_ff[STAGES].upd) begin
         pol_in = p5_ff;
      end else begin
         pol_in = word5_ff[DATA_W-1:0];
      end
      sat_in = ctl_ff[STAGES].upd && (clip5_ff || dclip);
   end

   assign mem_we    = clr_active_ff
                   || (ctl_ff[STAGES].vld && ctl_ff[STAGES].upd && advance);
   assign mem_waddr = clr_active_ff ? clr_addr_ff : ADDR_W'(ctl_ff[STAGES].point);
   assign mem_wdata = clr_active_ff ? '0 : wb_word;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         rdata_ff <= mem[ADDR_W'(req_point)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= ORDER_MAX; j++) begin
            num_coef_ff[j] <= '0;
         end
         for (int j = 1; j <= ORDER_MAX; j++) begin
            den_coef_ff[j] <= '0;
         end
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         ctl_ff        <= '{default: '0};
         out_vld_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_NUM_COEF_0: num_coef_ff[0] <= csr_wdata;
               CSR_NUM_COEF_1: num_coef_ff[1] <= csr_wdata;
               CSR_NUM_COEF_2: num_coef_ff[2] <= csr_wdata;
               CSR_NUM_COEF_3: num_coef_ff[3] <= csr_wdata;
               CSR_DEN_COEF_1: den_coef_ff[1] <= csr_wdata;
               CSR_DEN_COEF_2: den_coef_ff[2] <= csr_wdata;
               CSR_DEN_COEF_3: den_coef_ff[3] <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (clr_active_ff) begin
            if (clr_addr_ff == CLR_LAST) begin
               clr_active_ff <= 1'b0;
            end else begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
            end
         end
         if (advance) begin
            ctl_ff[1] <= ctl_in;
            for (int k = 2; k <= STAGES; k++) begin
               ctl_ff[k] <= ctl_ff[k-1];
            end
         end
         if (ctl_ff[STAGES].vld && advance) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff  <= req_sigma * req_field;
         u_ff     <= u_sat_in.val;
         clip2_ff <= u_sat_in.clip;
         word2_ff <= rdata_ff;
         for (int j = 0; j <= ORDER; j++) begin
            bu_ff[j] <= num_coef_ff[j] * u_ff;
         end
         clip3_ff <= clip2_ff;
         word3_ff <= word2_ff;
         p_ff     <= p_sat_in.val;
         clip4_ff <= clip3_ff | p_sat_in.clip;
         for (int j = 1; j <= ORDER; j++) begin
            bt_ff[j] <= bu_ff[j][PROD_W-1:COEF_FRAC];
         end
         word4_ff <= word3_ff;
         p5_ff    <= p_ff;
         clip5_ff <= clip4_ff;
         for (int j = 1; j <= ORDER; j++) begin
            bt5_ff[j] <= bt_ff[j];
            ap_ff[j]  <= den_coef_ff[j] * p_ff;
         end
         word5_ff <= word4_ff;
      end
      if (ctl_ff[STAGES].vld && advance) begin
         out_point_ff <= ctl_ff[STAGES].point;
         out_pol_ff   <= pol_in;
         out_upd_ff   <= ctl_ff[STAGES].upd;
         out_sat_ff   <= sat_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-POINT_W-DATA_W){1'b0}}, out_pol_ff, out_point_ff};
   assign rsp_tuser  = {out_sat_ff, out_upd_ff};

   always_comb begin
      dup_upd = 1'b0;
      for (int k = 2; k <= STAGES; k++) begin
         if (ctl_ff[1].vld && ctl_ff[1].upd && ctl_ff[k].vld && ctl_ff[k].upd
             && (ctl_ff[1].point == ctl_ff[k].point)) begin
            dup_upd = 1'b1;
         end
      end
   end

   a_no_dup_update: assert property (@(posedge clock) disable iff (reset)
      !dup_upd)
      else $error("two updates of one point in flight");

   a_writeback_vs_accept: assert property (@(posedge clock) disable iff (reset)
      (mem_we && !clr_active_ff && accept) |-> (ctl_ff[STAGES].point != req_point))
      else $error("beat taken while its point is written back");

   a_sat_needs_update: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[SAT_BIT]) |-> rsp_tuser[UPD_BIT])
      else $error("saturated flag on a beat without update");

   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      !clr_active_ff |=> !clr_active_ff)
      else $error("clearing sweep restarted");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import ppiir_pkg::*;

   localparam int POINTS = POINTS_DEF;
   localparam int ORDER  = ORDER_DEF;
   localparam int NREGS  = 7;
   localparam int PHASE_ITEMS = 210;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam longint MAX32 = 64'sd2147483647;
   localparam longint MIN32 = -64'sd2147483648;

   typedef struct packed {
      logic [POINT_W-1:0] point;
      logic [DATA_W-1:0]  pol;
      logic               upd;
      logic               sat;
   } pol_result_type;

   typedef struct packed {
      logic [1:0]         cfg_sel;
      logic [POINT_W-1:0] pt;
      logic [DATA_W-1:0]  w;
      logic [DATA_W-1:0]  s;
      logic               typed;
      logic [DATA_W-1:0]  pol;
      logic               upd;
      logic               sat;
   } probe_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [DATA_W-1:0]     csr_wdata = '0;

   int             coef_regs [NREGS];
   int             pol_mem [POINTS];
   int             dly_mem [ORDER][POINTS];
   bit             clip_hit;
   pol_result_type pending [$];
   pol_result_type want;
   int             errors = 0;

   int cfg_tab [3][NREGS] = '{
      '{0, 0, 0, 0, 0, 0, 0},
      '{32'h1000_0000, 32'h0800_0000, 32'hFC00_0000, 32'h0200_0000,
        32'hF800_0000, 32'h0400_0000, 32'hFE66_6666},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}
   };

   probe_row_type probes [20] = '{
      '{2'd0, 12'd0,    32'h0001_0000, 32'h0000_0000, 1'b1, 32'h0, 1'b0, 1'b0},
      '{2'd0, 12'd4095, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 32'h0, 1'b0, 1'b0},
      '{2'd0, 12'd4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h0, 1'b1, 1'b1},
      '{2'd0, 12'd0,    32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0, 1'b1, 1'b1},
      '{2'd0, 12'd1,    32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0, 1'b1, 1'b1},
      '{2'd0, 12'd1,    32'h0001_0000, 32'h0001_0000, 1'b1, 32'h0, 1'b1, 1'b0},
      '{2'd0, 12'd2,    32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0, 1'b1, 1'b0},
      '{2'd1, 12'd2,    32'h0001_0000, 32'h0001_0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd1, 12'd2,    32'h0001_0000, 32'h0001_0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd1, 12'd2,    32'h0001_0000, 32'h0001_0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd1, 12'd2,    32'h1234_5678, 32'h0000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd1, 12'd3,    32'hFFFE_0000, 32'h0003_0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd1, 12'd4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd1, 12'd3,    32'h0000_8000, 32'hFFF0_0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd2, 12'd5,    32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd2, 12'd5,    32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd2, 12'd5,    32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd2, 12'd5,    32'h0000_FFFF, 32'h0000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd2, 12'd6,    32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd2, 12'd0,    32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 1'b0}
   };

   per_point_iir_polarization_update_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int clip32(longint v);
      if (v > MAX32) begin
         clip_hit = 1'b1;
         return int'(MAX32);
      end
      if (v < MIN32) begin
         clip_hit = 1'b1;
         return int'(MIN32);
      end
      return int'(v);
   endfunction

   function automatic longint coef_mul(int c, int x);
      return (longint'(c) * longint'(x)) >>> COEF_FRAC;
   endfunction

   function automatic pol_result_type step_filter(logic [POINT_W-1:0] pt, int w, int s);
      pol_result_type r;
      int             u;
      int             p;
      clip_hit = 1'b0;
      r.point  = pt;
      r.pol    = pol_mem[pt];
      r.upd    = 1'b0;
      r.sat    = 1'b0;
      if (s != 0) begin
         u = clip32((longint'(s) * longint'(w)) >>> FIELD_FRAC);
         p = clip32(longint'(dly_mem[0][pt]) + coef_mul(coef_regs[CSR_NUM_COEF_0], u));
         for (int j = 0; j < ORDER - 1; j++)
            dly_mem[j][pt] = clip32(longint'(dly_mem[j+1][pt])
                                    + coef_mul(coef_regs[CSR_NUM_COEF_1 + j], u)
                                    - coef_mul(coef_regs[CSR_DEN_COEF_1 + j], p));
         dly_mem[ORDER-1][pt] = clip32(coef_mul(coef_regs[CSR_NUM_COEF_0 + ORDER], u)
                                       - coef_mul(coef_regs[CSR_DEN_COEF_1 + ORDER - 1], p));
         pol_mem[pt] = p;
         r.pol = p;
         r.upd = 1'b1;
         r.sat = clip_hit;
      end
      return r;
   endfunction

   task automatic flag(string what, longint got, longint exp);
      if (errors < 100)
         $display("mismatch %s: got %0h, want %0h at %0t", what, got, exp, $realtime);
      errors++;
   endtask

   task automatic next_gap(inout int quiet_left, output int gap);
      if (quiet_left > 0) begin
         gap = 0;
         quiet_left--;
      end else begin
         gap = $urandom_range(0, 4);
         if ($urandom_range(0, 39) == 0)
            quiet_left = 30;
      end
   endtask

   task automatic load_coefs(input int vals [NREGS]);
      csr_index_type idx;
      idx = CSR_NUM_COEF_0;
      do begin
         csr_wr_en <= 1'b1;
         csr_index <= idx;
         csr_wdata <= vals[idx];
         coef_regs[idx] = vals[idx];
         @(posedge clock);
         idx = idx.next();
      end while (idx != CSR_NUM_COEF_0);
      // spare index: the block drops it
      csr_index <= CSR_SPARE;
      csr_wdata <= $urandom();
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending.size() != 0)
         @(posedge clock);
   endtask

   task automatic offer(int gap, logic [POINT_W-1:0] pt, int w, int s,
                        bit typed, pol_result_type typed_res);
      pol_result_type r;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - POINT_W - 2 * DATA_W){1'b0}}, s, w, pt};
      do @(posedge clock); while (!req_tready);
      r = step_filter(pt, w, s);
      pending.push_back(typed ? typed_res : r);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending.size() == 0) begin
            flag("unexpected beat", rsp_tdata, 0);
         end else begin
            want = pending.pop_front();
            if (rsp_tdata[POINT_W-1:0] != want.point)
               flag("point", rsp_tdata[POINT_W-1:0], want.point);
            if (rsp_tdata[POINT_W +: DATA_W] != want.pol)
               flag("polarization", rsp_tdata[POINT_W +: DATA_W], want.pol);
            if (rsp_tuser[UPD_BIT] != want.upd)
               flag("was_updated", rsp_tuser[UPD_BIT], want.upd);
            if (rsp_tuser[SAT_BIT] != want.sat)
               flag("saturated", rsp_tuser[SAT_BIT], want.sat);
         end
      end
   end

   initial begin : receiver
      int gap;
      int quiet_left;
      int taken;
      quiet_left = 0;
      taken = 0;
      wait (!reset);
      forever begin
         next_gap(quiet_left, gap);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         // hold off long enough to back up the pipeline into the input
         if (taken == 150) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int                 gap;
      int                 quiet_left;
      int                 cur_sel;
      int                 w;
      int                 s;
      int                 coefs [NREGS];
      logic [POINT_W-1:0] pt;
      probe_row_type      row;
      pol_result_type     typed_res;
      quiet_left = 0;
      foreach (pol_mem[i]) pol_mem[i] = 0;
      foreach (dly_mem[j, i]) dly_mem[j][i] = 0;
      foreach (coef_regs[i]) coef_regs[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      load_coefs(cfg_tab[0]);
      cur_sel = 0;

      foreach (probes[i]) begin
         row = probes[i];
         if (row.cfg_sel != cur_sel) begin
            settle();
            cur_sel = row.cfg_sel;
            load_coefs(cfg_tab[cur_sel]);
         end
         typed_res = '{row.pt, row.pol, row.upd, row.sat};
         next_gap(quiet_left, gap);
         offer(gap, row.pt, row.w, row.s, row.typed, typed_res);
      end

      for (int ph = 0; ph < 4; ph++) begin
         settle();
         foreach (coefs[k]) begin
            if (ph == 1 || (ph == 3 && $urandom_range(0, 1) == 1))
               coefs[k] = $urandom();
            else
               coefs[k] = int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
         end
         load_coefs(coefs);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 9) < 6)
               pt = POINT_W'($urandom_range(0, 7));
            else
               pt = POINT_W'($urandom_range(0, POINTS - 1));
            if ($urandom_range(0, 9) < 3)
               w = $urandom();
            else
               w = int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            case ($urandom_range(0, 19))
               0, 1, 2, 3: s = 0;
               4, 5, 6, 7, 8: s = $urandom();
               default: s = int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            endcase
            next_gap(quiet_left, gap);
            offer(gap, pt, w, s, 1'b0, '0);
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin : watchdog
      #(400_000 * 20);
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/ppiir_pkg.sv
hw/rtl/per_point_iir_polarization_update_unit.sv
test/tb_top.sv
